@@ design/mns_pkg.sv @@
// Shared types, constants and the duty lookup table for the melody note sequencer.
package mns_pkg;

   localparam int MAX_NOTES_DEF = 64;

   localparam int FREQ_W    = 16;
   localparam int MS_W      = 16;
   localparam int ENTRY_W   = FREQ_W + MS_W;
   localparam int TIME_W    = 32;
   localparam int DUTY_W    = 8;
   localparam int VOL_W     = 2;
   localparam int LEN_W     = 7;
   localparam int NIDX_W    = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_ADDR_W-1:0] CSR_AUDIO_EN = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLUME   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MUSIC_EN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_EN  = 3'd4;

   localparam logic [DUTY_W-1:0] DUTY_STEPS [4] = '{8'd0, 8'd6, 8'd12, 8'd26};

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_TICK  = 2'd3
   } act_type;

   typedef struct packed {
      act_type                 action;
      logic [NIDX_W-1:0]       note_index;
      logic [FREQ_W-1:0]       note_freq;
      logic [MS_W-1:0]         note_ms;
      logic [TIME_W-1:0]       now_ms;
   } req_type;

   typedef struct packed {
      logic                    audio_en;
      logic [VOL_W-1:0]        volume;
      logic                    music_en;
      logic [LEN_W-1:0]        length;
      logic                    loop_en;
   } cfg_type;

   typedef struct packed {
      logic                    speaker_write;
      logic [FREQ_W-1:0]       tone_freq;
      logic [DUTY_W-1:0]       tone_duty;
      logic                    playing;
   } rsp_type;

endpackage

@@ design/mns_note_mem.sv @@
// Note table memory: one write port, two registered read ports with write-through.
module mns_note_mem #(
   parameter int Depth = mns_pkg::MAX_NOTES_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(Depth)-1:0]      wr_addr,
   input  logic [mns_pkg::ENTRY_W-1:0]   wr_data,
   input  logic [$clog2(Depth)-1:0]      rd_addr_a,
   input  logic [$clog2(Depth)-1:0]      rd_addr_b,
   output logic [mns_pkg::ENTRY_W-1:0]   rd_data_a,
   output logic [mns_pkg::ENTRY_W-1:0]   rd_data_b
);

   logic [mns_pkg::ENTRY_W-1:0] note_mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem_ff[wr_addr] <= wr_data;
      end
   end

   // forward a same-cycle write so the read ports never see a stale entry
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr_a)) begin
         rd_data_a <= wr_data;
      end else begin
         rd_data_a <= note_mem_ff[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
         rd_data_b <= wr_data;
      end else begin
         rd_data_b <= note_mem_ff[rd_addr_b];
      end
   end

endmodule

@@ design/mns_play_ctrl.sv @@
// Playback state and per-item decision logic of the note sequencer.
module mns_play_ctrl #(
   parameter int MaxNotes = mns_pkg::MAX_NOTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              proc,
   input  mns_pkg::req_type                  req,
   input  mns_pkg::cfg_type                  cfg,
   input  logic [mns_pkg::LEN_W-1:0]         len_nxt,
   input  logic                              play_clr,
   input  logic [mns_pkg::ENTRY_W-1:0]       cur_entry,
   input  logic [mns_pkg::ENTRY_W-1:0]       succ_entry,
   output logic                              wr_en,
   output logic [$clog2(MaxNotes)-1:0]       wr_addr,
   output logic [mns_pkg::ENTRY_W-1:0]       wr_data,
   output logic [$clog2(MaxNotes)-1:0]       cur_addr,
   output logic [$clog2(MaxNotes)-1:0]       succ_addr,
   output mns_pkg::rsp_type                  rsp,
   output logic                              active
);

   localparam int IdxW = $clog2(MaxNotes);

   logic [IdxW-1:0]                 pos_ff, pos_in;
   logic [mns_pkg::TIME_W-1:0]      begin_ff, begin_in;
   logic                            started_ff, started_in;
   logic                            active_ff, active_in;

   logic [IdxW:0]                   pos_p1;
   logic [IdxW:0]                   nxt_p1;
   logic                            at_end;
   logic                            due;
   logic [mns_pkg::TIME_W-1:0]      elapsed;
   logic [mns_pkg::FREQ_W-1:0]      cur_freq;
   logic [mns_pkg::MS_W-1:0]        cur_ms;
   logic [mns_pkg::FREQ_W-1:0]      succ_freq;
   logic                            spk;
   logic [mns_pkg::FREQ_W-1:0]      freq;

   assign cur_freq  = cur_entry[mns_pkg::ENTRY_W-1:mns_pkg::MS_W];
   assign cur_ms    = cur_entry[mns_pkg::MS_W-1:0];
   assign succ_freq = succ_entry[mns_pkg::ENTRY_W-1:mns_pkg::MS_W];

   assign pos_p1  = {1'b0, pos_ff} + 1'b1;
   assign at_end  = (32'(pos_p1) >= 32'(cfg.length)) || (32'(pos_p1) >= MaxNotes);
   assign elapsed = req.now_ms - begin_ff;
   assign due     = elapsed >= 32'(cur_ms);

   always_comb begin
      pos_in     = pos_ff;
      begin_in   = begin_ff;
      started_in = started_ff;
      active_in  = active_ff;
      spk        = 1'b0;
      freq       = '0;
      wr_en      = 1'b0;
      wr_addr    = IdxW'(req.note_index);
      wr_data    = {req.note_freq, req.note_ms};
      if (proc) begin
         case (req.action)
            mns_pkg::ACT_WRITE: begin
               wr_en = 32'(req.note_index) < MaxNotes;
            end
            mns_pkg::ACT_START: begin
               if (cfg.audio_en && cfg.music_en && (cfg.volume != '0) &&
                   (cfg.length != '0)) begin
                  pos_in     = '0;
                  started_in = 1'b0;
                  active_in  = 1'b1;
               end
            end
            mns_pkg::ACT_STOP: begin
               active_in = 1'b0;
               spk       = 1'b1;
            end
            mns_pkg::ACT_TICK: begin
               if (active_ff && cfg.audio_en) begin
                  if (!started_ff) begin
                     started_in = 1'b1;
                     begin_in   = req.now_ms;
                     spk        = 1'b1;
                     freq       = cur_freq;
                  end else if (due) begin
                     if (at_end && !cfg.loop_en) begin
                        active_in = 1'b0;
                        spk       = 1'b1;
                     end else begin
                        pos_in   = at_end ? '0 : pos_p1[IdxW-1:0];
                        begin_in = req.now_ms;
                        spk      = 1'b1;
                        freq     = succ_freq;
                     end
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
      if (play_clr) begin
         active_in = 1'b0;
      end
   end

   // read addresses follow the next position so the registered data lines up
   assign nxt_p1    = {1'b0, pos_in} + 1'b1;
   assign cur_addr  = pos_in;
   assign succ_addr = ((32'(nxt_p1) >= 32'(len_nxt)) || (32'(nxt_p1) >= MaxNotes)) ?
                      '0 : nxt_p1[IdxW-1:0];

   always_comb begin
      rsp.speaker_write = spk;
      rsp.tone_freq     = freq;
      rsp.tone_duty     = (spk && (freq != '0)) ? mns_pkg::DUTY_STEPS[cfg.volume] : '0;
      rsp.playing       = active_in;
   end

   assign active = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         begin_ff   <= '0;
         started_ff <= 1'b0;
         active_ff  <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         begin_ff   <= begin_in;
         started_ff <= started_in;
         active_ff  <= active_in;
      end
   end

endmodule

@@ design/melody_note_sequencer_unit.sv @@
// Melody note sequencer top level: input register, playback control, result register.
//
// One item enters per cycle while the input is not stalled; the item is held in an input
// register, decided by the playback logic against the note table and the playback state,
// and lands in a result register that waits for the consumer. Sustained rate is one item
// per clock while the consumer does not stall; the note table is a memory with one
// write port and two registered read ports (current note and following note), whose
// addresses track the next playback position so the entries are ready when a tick is
// decided. Note writes go through to the read ports in the same cycle. Register writes
// take effect at the next clock and are meant for times with no item in flight; turning
// off audio, music or volume ends playback at once.
module melody_note_sequencer_unit #(
   parameter int MaxNotes = mns_pkg::MAX_NOTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [mns_pkg::NIDX_W-1:0]        req_note_index,
   input  logic [mns_pkg::FREQ_W-1:0]        req_note_freq,
   input  logic [mns_pkg::MS_W-1:0]          req_note_ms,
   input  logic [mns_pkg::TIME_W-1:0]        req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_speaker_write,
   output logic [mns_pkg::FREQ_W-1:0]        rsp_tone_freq,
   output logic [mns_pkg::DUTY_W-1:0]        rsp_tone_duty,
   output logic                              rsp_playing,
   input  logic                              csr_we,
   input  logic [mns_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mns_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IdxW = $clog2(MaxNotes);

   mns_pkg::cfg_type                 cfg_ff, cfg_in;
   logic                             play_clr;

   logic                             s1_vld_ff, s1_vld_in;
   mns_pkg::req_type                 s1_req_ff;
   logic                             rsp_vld_ff, rsp_vld_in;
   mns_pkg::rsp_type                 rsp_ff;
   logic                             req_take;
   logic                             rsp_load;

   logic                             mem_wr_en;
   logic [IdxW-1:0]                  mem_wr_addr;
   logic [mns_pkg::ENTRY_W-1:0]      mem_wr_data;
   logic [IdxW-1:0]                  cur_addr;
   logic [IdxW-1:0]                  succ_addr;
   logic [mns_pkg::ENTRY_W-1:0]      cur_entry;
   logic [mns_pkg::ENTRY_W-1:0]      succ_entry;
   mns_pkg::rsp_type                 ctrl_rsp;
   logic                             play_active;

   // configuration registers
   always_comb begin
      cfg_in   = cfg_ff;
      play_clr = 1'b0;
      if (csr_we) begin
         case (csr_addr)
            mns_pkg::CSR_AUDIO_EN: begin
               cfg_in.audio_en = csr_wdata[0];
               play_clr        = !csr_wdata[0];
            end
            mns_pkg::CSR_VOLUME: begin
               cfg_in.volume = csr_wdata[mns_pkg::VOL_W-1:0];
               play_clr      = (csr_wdata[mns_pkg::VOL_W-1:0] == '0);
            end
            mns_pkg::CSR_MUSIC_EN: begin
               cfg_in.music_en = csr_wdata[0];
               play_clr        = !csr_wdata[0];
            end
            mns_pkg::CSR_LENGTH: begin
               // saturate to the table depth
               cfg_in.length = (32'(csr_wdata) > MaxNotes) ?
                               mns_pkg::LEN_W'(MaxNotes) : csr_wdata;
            end
            mns_pkg::CSR_LOOP_EN: begin
               cfg_in.loop_en = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.audio_en <= 1'b1;
         cfg_ff.volume   <= 2'd2;
         cfg_ff.music_en <= 1'b1;
         cfg_ff.length   <= '0;
         cfg_ff.loop_en  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline flow: input register, then result register
   assign rsp_load   = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = s1_vld_ff && !rsp_load;
   assign req_take   = req_valid && !req_stall;
   assign s1_vld_in  = req_take || (s1_vld_ff && !rsp_load);
   assign rsp_vld_in = rsp_load || (rsp_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.action     <= mns_pkg::act_type'(req_action);
         s1_req_ff.note_index <= req_note_index;
         s1_req_ff.note_freq  <= req_note_freq;
         s1_req_ff.note_ms    <= req_note_ms;
         s1_req_ff.now_ms     <= req_now_ms;
      end
      if (rsp_load) begin
         rsp_ff <= ctrl_rsp;
      end
   end

   mns_play_ctrl #(
      .MaxNotes (MaxNotes)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .proc       (rsp_load),
      .req        (s1_req_ff),
      .cfg        (cfg_ff),
      .len_nxt    (cfg_in.length),
      .play_clr   (play_clr),
      .cur_entry  (cur_entry),
      .succ_entry (succ_entry),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .cur_addr   (cur_addr),
      .succ_addr  (succ_addr),
      .rsp        (ctrl_rsp),
      .active     (play_active)
   );

   mns_note_mem #(
      .Depth (MaxNotes)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (cur_addr),
      .rd_addr_b (succ_addr),
      .rd_data_a (cur_entry),
      .rd_data_b (succ_entry)
   );

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_speaker_write = rsp_ff.speaker_write;
   assign rsp_tone_freq     = rsp_ff.tone_freq;
   assign rsp_tone_duty     = rsp_ff.tone_duty;
   assign rsp_playing       = rsp_ff.playing;

   // a result without a speaker write carries no tone
   a_quiet_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.speaker_write) |-> (rsp_ff.tone_freq == '0 &&
                                                 rsp_ff.tone_duty == '0))
      else $error("result without speaker write carries a tone");

   // a rest is never driven with a nonzero duty
   a_rest_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.tone_freq == '0) |-> (rsp_ff.tone_duty == '0))
      else $error("rest written with nonzero duty");

   // a stop lands as a silent speaker write with playback ended
   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && s1_req_ff.action == mns_pkg::ACT_STOP && !play_clr) |=>
         (rsp_vld_ff && rsp_ff.speaker_write && !rsp_ff.playing && !play_active))
      else $error("stop did not end playback");

   // disabling audio, music or volume ends playback at the next clock
   a_disable_stops: assert property (@(posedge clock) disable iff (reset)
      play_clr |=> !play_active)
      else $error("playback survived a disable write");

endmodule
